>>> hdl/tcd_pkg.sv
package tcd_pkg;

    // Request types
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Register selects
    localparam logic [1:0] SEL_DATA_HI = 2'd0;
    localparam logic [1:0] SEL_DATA_LO = 2'd1;
    localparam logic [1:0] SEL_MASK_HI = 2'd2;
    localparam logic [1:0] SEL_MASK_LO = 2'd3;

    // Command address field
    localparam logic [2:0] ADDR_MIX    = 3'd0;
    localparam logic [2:0] ADDR_BASS   = 3'd1;
    localparam logic [2:0] ADDR_TREBLE = 3'd2;
    localparam logic [2:0] ADDR_MASTER = 3'd3;
    localparam logic [2:0] ADDR_RIGHT  = 3'd4;
    localparam logic [2:0] ADDR_LEFT   = 3'd5;

    localparam int          WORD_W      = 16;
    localparam int          CMD_MIN_LEN = 11;
    localparam logic [1:0]  CMD_LEAD    = 2'b10;
    localparam logic [4:0]  XFER_TICKS  = 5'd16;

    // Settings after reset
    localparam logic [5:0] MASTER_RST = 6'd40;
    localparam logic [4:0] LEFT_RST   = 5'd20;
    localparam logic [4:0] RIGHT_RST  = 5'd20;
    localparam logic [3:0] BASS_RST   = 4'd6;
    localparam logic [3:0] TREBLE_RST = 4'd6;
    localparam logic [1:0] MIX_RST    = 2'd0;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] reg_sel;
        logic [7:0] write_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       busy_res;
        logic [5:0] master_level;
        logic [4:0] left_level;
        logic [4:0] right_level;
        logic [3:0] bass_code;
        logic [3:0] treble_code;
        logic [1:0] mix_mode;
    } t_out;

    typedef struct packed {
        logic       hit;
        logic [2:0] addr;
        logic [5:0] value;
    } t_cmd;

endpackage

>>> hdl/tcd_cmd_decode.sv
module tcd_cmd_decode (
    input  logic [tcd_pkg::WORD_W-1:0] i_data_word,
    input  logic [tcd_pkg::WORD_W-1:0] i_mask_word,
    output tcd_pkg::t_cmd              o_cmd
);

    logic [tcd_pkg::WORD_W-1:0] win;
    logic [tcd_pkg::WORD_W-1:0] ext;
    logic [tcd_pkg::WORD_W-1:0] shifted;

    // Only one run of mask ones can reach the minimum length in a word, so
    // test every long window s..e for being exactly a maximal run.
    always_comb begin
        o_cmd   = '0;
        win     = '0;
        ext     = '0;
        shifted = '0;
        for (int s = tcd_pkg::CMD_MIN_LEN - 1; s < tcd_pkg::WORD_W; s++) begin
            for (int e = 0; e <= s - (tcd_pkg::CMD_MIN_LEN - 1); e++) begin
                for (int b = 0; b < tcd_pkg::WORD_W; b++) begin
                    win[b] = (b >= e) && (b <= s);
                    ext[b] = (b >= e - 1) && (b <= s + 1);
                end
                shifted = i_data_word >> e;
                if (((i_mask_word & ext) == win)
                    && ({i_data_word[s], i_data_word[s-1]} == tcd_pkg::CMD_LEAD)) begin
                    o_cmd.hit   = 1'b1;
                    o_cmd.addr  = shifted[8:6];
                    o_cmd.value = shifted[5:0];
                end
            end
        end
    end

endmodule

>>> hdl/microwire_tone_command_decoder_top.sv
// Channel  | handshake                 | beat
// ---------+---------------------------+--------------------------------------
// request  | i_in_valid / o_in_ready   | i_in_data  (req_type, reg_sel, byte)
// result   | o_out_valid / i_out_ready | o_out_data (readback, busy, settings)
//
// One beat in, one beat out; a request beat is taken every cycle while the
// result register is empty or being drained, and its result appears the
// next cycle. Latency and throughput are set by the single result register.
// Reset (synchronous, active low) clears the words, ends any transfer and
// restores the default settings. A stalled result holds the request side.
module microwire_tone_command_decoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcd_pkg::t_out o_out_data
);

    logic [15:0] r_data_word,  n_data_word;
    logic [15:0] r_mask_word,  n_mask_word;
    logic [15:0] r_shift_view, n_shift_view;
    logic [4:0]  r_steps_left, n_steps_left;
    logic [5:0]  r_master,     n_master;
    logic [4:0]  r_left,       n_left;
    logic [4:0]  r_right,      n_right;
    logic [3:0]  r_bass,       n_bass;
    logic [3:0]  r_treble,     n_treble;
    logic [1:0]  r_mix,        n_mix;
    logic        r_out_valid;
    tcd_pkg::t_out r_out,      n_out;

    logic          in_accept;
    logic [7:0]    rd_byte;
    logic [4:0]    shift_amt;
    tcd_pkg::t_cmd cmd;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    tcd_cmd_decode u_cmd_decode (
        .i_data_word (r_data_word),
        .i_mask_word (r_mask_word),
        .o_cmd       (cmd)
    );

    assign shift_amt = tcd_pkg::XFER_TICKS - n_steps_left;

    always_comb begin
        n_data_word  = r_data_word;
        n_mask_word  = r_mask_word;
        n_shift_view = r_shift_view;
        n_steps_left = r_steps_left;
        n_master     = r_master;
        n_left       = r_left;
        n_right      = r_right;
        n_bass       = r_bass;
        n_treble     = r_treble;
        n_mix        = r_mix;
        rd_byte      = '0;

        unique case (i_in_data.req_type)
            tcd_pkg::REQ_READ: begin
                unique case (i_in_data.reg_sel)
                    tcd_pkg::SEL_DATA_HI: rd_byte = r_shift_view[15:8];
                    tcd_pkg::SEL_DATA_LO: rd_byte = r_shift_view[7:0];
                    tcd_pkg::SEL_MASK_HI: rd_byte = r_mask_word[15:8];
                    default:              rd_byte = r_mask_word[7:0];
                endcase
            end
            tcd_pkg::REQ_WRITE: begin
                unique case (i_in_data.reg_sel)
                    tcd_pkg::SEL_DATA_HI: n_data_word[15:8] = i_in_data.write_byte;
                    tcd_pkg::SEL_DATA_LO: begin
                        n_data_word[7:0] = i_in_data.write_byte;
                        // start a transfer only from idle
                        if (r_steps_left == '0) begin
                            n_shift_view = {r_data_word[15:8], i_in_data.write_byte};
                            n_steps_left = tcd_pkg::XFER_TICKS;
                        end
                    end
                    tcd_pkg::SEL_MASK_HI: n_mask_word[15:8] = i_in_data.write_byte;
                    default:              n_mask_word[7:0]  = i_in_data.write_byte;
                endcase
            end
            tcd_pkg::REQ_TICK: begin
                if (r_steps_left != '0) begin
                    n_steps_left = r_steps_left - 5'd1;
                    n_shift_view = 16'(r_data_word << shift_amt);
                    // last tick: apply the command found in the mask
                    if (r_steps_left == 5'd1 && cmd.hit) begin
                        unique case (cmd.addr)
                            tcd_pkg::ADDR_MIX:    n_mix    = cmd.value[1:0];
                            tcd_pkg::ADDR_BASS:   n_bass   = cmd.value[3:0];
                            tcd_pkg::ADDR_TREBLE: n_treble = cmd.value[3:0];
                            tcd_pkg::ADDR_MASTER: n_master = cmd.value;
                            tcd_pkg::ADDR_RIGHT:  n_right  = cmd.value[4:0];
                            tcd_pkg::ADDR_LEFT:   n_left   = cmd.value[4:0];
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase

        n_out.read_byte    = rd_byte;
        n_out.busy_res     = (n_steps_left != '0);
        n_out.master_level = n_master;
        n_out.left_level   = n_left;
        n_out.right_level  = n_right;
        n_out.bass_code    = n_bass;
        n_out.treble_code  = n_treble;
        n_out.mix_mode     = n_mix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_word  <= '0;
            r_mask_word  <= '0;
            r_shift_view <= '0;
            r_steps_left <= '0;
            r_master     <= tcd_pkg::MASTER_RST;
            r_left       <= tcd_pkg::LEFT_RST;
            r_right      <= tcd_pkg::RIGHT_RST;
            r_bass       <= tcd_pkg::BASS_RST;
            r_treble     <= tcd_pkg::TREBLE_RST;
            r_mix        <= tcd_pkg::MIX_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_data_word  <= n_data_word;
                r_mask_word  <= n_mask_word;
                r_shift_view <= n_shift_view;
                r_steps_left <= n_steps_left;
                r_master     <= n_master;
                r_left       <= n_left;
                r_right      <= n_right;
                r_bass       <= n_bass;
                r_treble     <= n_treble;
                r_mix        <= n_mix;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload: load on every accepted beat
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    a_steps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps_left <= tcd_pkg::XFER_TICKS)
        else $error("transfer step count out of range");

    a_busy_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.busy_res == (r_steps_left != '0)))
        else $error("busy flag disagrees with transfer state");

    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.req_type == tcd_pkg::REQ_TICK && r_steps_left != '0)
        |=> (r_steps_left == $past(r_steps_left) - 5'd1))
        else $error("tick did not advance the transfer");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted beat produced no result");

endmodule
